// File: hw/rtl/tpm_pkg.sv
// Package with the shared types, codes and constants of the TLB and page table MMU.
package tpm_pkg;

  localparam int PAGE_W = 5;
  localparam int FRAME_W = 4;
  localparam int OWNER_W = 16;
  localparam int USE_W = 16;
  localparam int LFSR_W = 16;

  localparam int PAGE_SPAN = 32;
  localparam int FRAME_SPAN = 16;

  localparam int DEF_PAGES = 32;
  localparam int DEF_TLB_ENTRIES = 8;
  localparam int DEF_FRAMES = 16;

  localparam logic [USE_W-1:0] USE_MAX = 16'hFFFF;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    OP_READ = 2'd0,
    OP_WRITE = 2'd1,
    OP_INSTALL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_blocked;
  } status_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/tpm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tpm_ctrl.sv
// Controller state machine that sequences the clearing pass, capture and execute steps.
module tpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpm_pkg::status_t  status,
  output tpm_pkg::cmd_t     cmd
);

  tpm_pkg::state_t state;
  tpm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      tpm_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = tpm_pkg::ST_IDLE;
        end
      end
      tpm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = tpm_pkg::ST_EXEC;
        end
      end
      tpm_pkg::ST_EXEC: begin
        if (!status.out_blocked) begin
          cmd.execute = 1'b1;
          state_next = tpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tpm_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: hw/rtl/tpm_slot_sel.sv
// Replacement slot selector: next LFSR value and its residue modulo the TLB size.
module tpm_slot_sel #(
  parameter int TLB_ENTRIES = tpm_pkg::DEF_TLB_ENTRIES
) (
  input  logic                                             clk,
  input  logic [tpm_pkg::LFSR_W-1:0]                       lfsr,
  output logic [tpm_pkg::LFSR_W-1:0]                       lfsr_nx,
  output logic [((TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1)-1:0] slot
);

  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int RW = $clog2(2 * TLB_ENTRIES);
  localparam int unsigned RECIP = 65536 / TLB_ENTRIES;
  localparam logic [tpm_pkg::LFSR_W-1:0] NCONST = tpm_pkg::LFSR_W'(TLB_ENTRIES);
  localparam logic [RW-1:0] NRES = RW'(TLB_ENTRIES);

  logic [tpm_pkg::LFSR_W-1:0] step;
  logic [31:0]                prod;
  logic [tpm_pkg::LFSR_W-1:0] quot;
  logic [tpm_pkg::LFSR_W-1:0] back;
  logic [tpm_pkg::LFSR_W-1:0] diff;
  logic [RW-1:0]              rem0;
  logic [RW-1:0]              rem1;

  assign step = tpm_pkg::lfsr_step(lfsr);
  assign prod = 32'(step) * 32'(RECIP);

  always_ff @(posedge clk) begin
    lfsr_nx <= step;
    quot <= prod[31:16];
  end

  // The estimated quotient is low by at most one, so one correction step is enough.
  assign back = quot * NCONST;
  assign diff = lfsr_nx - back;
  assign rem0 = diff[RW-1:0];
  assign rem1 = (rem0 >= NRES) ? (rem0 - NRES) : rem0;
  assign slot = rem1[TW-1:0];

endmodule

// File: hw/rtl/tpm_datapath.sv
// Datapath with the page table RAM, TLB registers, replacement LFSR and result register.
module tpm_datapath #(
  parameter int PAGES = tpm_pkg::DEF_PAGES,
  parameter int TLB_ENTRIES = tpm_pkg::DEF_TLB_ENTRIES,
  parameter int FRAMES = tpm_pkg::DEF_FRAMES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tpm_pkg::cmd_t                cmd,
  output tpm_pkg::status_t             status,
  input  logic                         cfg_valid,
  input  logic [tpm_pkg::OWNER_W-1:0]  requester_id,
  input  logic [1:0]                   operation,
  input  logic [tpm_pkg::PAGE_W-1:0]   page_number,
  input  logic [tpm_pkg::FRAME_W-1:0]  frame_number,
  input  logic                         map_valid,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         tlb_hit,
  output logic                         table_hit,
  output logic                         page_fault,
  output logic [tpm_pkg::FRAME_W-1:0]  frame_out,
  output logic [tpm_pkg::PAGE_W-1:0]   page_out
);

  localparam int PAGE_LIM = (PAGES < tpm_pkg::PAGE_SPAN) ? PAGES : tpm_pkg::PAGE_SPAN;
  localparam int FRAME_LIM = (FRAMES < tpm_pkg::FRAME_SPAN) ? FRAMES : tpm_pkg::FRAME_SPAN;
  localparam int IW = $clog2(PAGE_LIM);
  localparam int FW = (FRAME_LIM > 1) ? $clog2(FRAME_LIM) : 1;
  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int VALID_BIT = FW;
  localparam int DIRTY_BIT = FW + 1;
  localparam int OWN_LO = FW + 2;
  localparam int USE_LO = OWN_LO + tpm_pkg::OWNER_W;
  localparam int WORD_W = USE_LO + tpm_pkg::USE_W;

  logic [IW-1:0] page_map [tpm_pkg::PAGE_SPAN];
  logic [FW-1:0] frame_map [tpm_pkg::FRAME_SPAN];

  for (genvar g = 0; g < tpm_pkg::PAGE_SPAN; g++) begin : g_page_map
    localparam int unsigned PM = g % PAGES;
    assign page_map[g] = IW'(PM);
  end

  for (genvar g = 0; g < tpm_pkg::FRAME_SPAN; g++) begin : g_frame_map
    localparam int unsigned FM = g % FRAMES;
    assign frame_map[g] = FW'(FM);
  end

  logic [tpm_pkg::OWNER_W-1:0] requester;

  always_ff @(posedge clk) begin
    if (rst) begin
      requester <= '0;
    end else if (cfg_valid) begin
      requester <= requester_id;
    end
  end

  logic [IW-1:0]          clr_addr;
  logic [TLB_ENTRIES-1:0] tlb_present;
  logic [IW-1:0]          tlb_tag [TLB_ENTRIES];
  logic [FW-1:0]          tlb_frame [TLB_ENTRIES];
  logic [tpm_pkg::LFSR_W-1:0] lfsr;
  logic [tpm_pkg::LFSR_W-1:0] lfsr_nx;
  logic [TW-1:0]          slot;

  logic [IW-1:0]          in_idx;
  logic [FW-1:0]          in_frame;
  logic [TLB_ENTRIES-1:0] in_match;
  logic [FW-1:0]          in_hit_frame;

  assign in_idx = page_map[page_number];
  assign in_frame = frame_map[frame_number];

  always_comb begin
    in_hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      in_match[i] = tlb_present[i] && (tlb_tag[i] == in_idx);
    end
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (in_match[i]) begin
        in_hit_frame = tlb_frame[i];
      end
    end
  end

  logic [1:0]                op_q;
  logic [tpm_pkg::PAGE_W-1:0] page_q;
  logic [IW-1:0]             idx_q;
  logic [FW-1:0]             frame_q;
  logic                      map_q;
  logic [TLB_ENTRIES-1:0]    match_q;
  logic                      hit_q;
  logic [FW-1:0]             hit_frame_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= operation;
      page_q <= page_number;
      idx_q <= in_idx;
      frame_q <= in_frame;
      map_q <= map_valid;
      match_q <= in_match;
      hit_q <= |in_match;
      hit_frame_q <= in_hit_frame;
    end
  end

  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] word_new;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  logic                       rd_valid;
  logic [FW-1:0]              rd_frame;
  logic [tpm_pkg::USE_W-1:0]  rd_use;
  logic [tpm_pkg::USE_W-1:0]  use_inc;
  logic                       upd_we;
  logic                       tlb_fill;
  logic                       tlb_fix;
  logic                       res_tlb;
  logic                       res_table;
  logic                       res_fault;
  logic [FW-1:0]              res_frame;

  assign rd_valid = rdata[VALID_BIT];
  assign rd_frame = rdata[FW-1:0];
  assign rd_use = rdata[USE_LO +: tpm_pkg::USE_W];
  assign use_inc = (rd_use == tpm_pkg::USE_MAX) ? rd_use : (rd_use + 16'd1);

  always_comb begin
    word_new = rdata;
    upd_we = 1'b0;
    tlb_fill = 1'b0;
    tlb_fix = 1'b0;
    res_tlb = 1'b0;
    res_table = 1'b0;
    res_fault = 1'b0;
    res_frame = '0;
    case (op_q)
      tpm_pkg::OP_READ, tpm_pkg::OP_WRITE: begin
        upd_we = 1'b1;
        word_new[USE_LO +: tpm_pkg::USE_W] = use_inc;
        if (hit_q) begin
          res_tlb = 1'b1;
          res_frame = hit_frame_q;
        end else if (rd_valid) begin
          res_table = 1'b1;
          res_frame = rd_frame;
          tlb_fill = 1'b1;
          if (op_q == tpm_pkg::OP_WRITE) begin
            word_new[DIRTY_BIT] = 1'b1;
          end
        end else begin
          res_fault = 1'b1;
          word_new[OWN_LO +: tpm_pkg::OWNER_W] = requester;
          if (op_q == tpm_pkg::OP_WRITE) begin
            word_new[DIRTY_BIT] = 1'b1;
          end
        end
      end
      tpm_pkg::OP_INSTALL: begin
        upd_we = 1'b1;
        tlb_fix = 1'b1;
        word_new[VALID_BIT] = map_q;
        word_new[FW-1:0] = frame_q;
      end
      default: begin
      end
    endcase
  end

  assign ram_we = cmd.clear_step | (cmd.execute & upd_we);
  assign ram_waddr = cmd.clear_step ? clr_addr : idx_q;
  assign ram_wdata = cmd.clear_step ? '0 : word_new;

  tpm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(PAGE_LIM)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(cmd.capture),
    .raddr(in_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clear_last = (clr_addr == IW'(PAGE_LIM - 1));
  assign status.out_blocked = out_valid & ~out_ready;

  tpm_slot_sel #(
    .TLB_ENTRIES(TLB_ENTRIES)
  ) u_slot_sel (
    .clk(clk),
    .lfsr(lfsr),
    .lfsr_nx(lfsr_nx),
    .slot(slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= tpm_pkg::LFSR_SEED;
      tlb_present <= '0;
    end else if (cmd.execute) begin
      if (tlb_fill) begin
        lfsr <= lfsr_nx;
        tlb_present[slot] <= 1'b1;
      end
      if (tlb_fix && !map_q) begin
        tlb_present <= tlb_present & ~match_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (tlb_fill) begin
        tlb_tag[slot] <= idx_q;
        tlb_frame[slot] <= rd_frame;
      end
      if (tlb_fix && map_q) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (match_q[i]) begin
            tlb_frame[i] <= frame_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      tlb_hit <= res_tlb;
      table_hit <= res_table;
      page_fault <= res_fault;
      frame_out <= tpm_pkg::FRAME_W'(res_frame);
      page_out <= page_q;
    end
  end

endmodule

// File: hw/rtl/tlb_page_table_mmu.sv
// Top level of the MMU with a page table, a fully associative TLB and random replacement.
//
// Each transaction on the input channel passes through a capture step and an execute step: the
// page table entry is read from the page table RAM in the cycle the transaction is accepted, and
// in the execute state it is written back, the TLB is updated and the result goes into the output
// register. The block accepts a new transaction only after the last one has executed, and a
// result that is not taken holds the block in its execute state. After reset the page table RAM
// is cleared one entry per cycle, all min(PAGES, 32) entries, before the first input transaction
// is accepted. The requester_id register is always ready.
module tlb_page_table_mmu #(
  parameter int PAGES = tpm_pkg::DEF_PAGES,
  parameter int TLB_ENTRIES = tpm_pkg::DEF_TLB_ENTRIES,
  parameter int FRAMES = tpm_pkg::DEF_FRAMES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [tpm_pkg::PAGE_W-1:0]   page_number,
  input  logic [tpm_pkg::FRAME_W-1:0]  frame_number,
  input  logic                         map_valid,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         tlb_hit,
  output logic                         table_hit,
  output logic                         page_fault,
  output logic [tpm_pkg::FRAME_W-1:0]  frame_out,
  output logic [tpm_pkg::PAGE_W-1:0]   page_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpm_pkg::OWNER_W-1:0]  requester_id
);

  tpm_pkg::cmd_t    cmd;
  tpm_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tpm_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status(status),
    .cmd(cmd)
  );

  tpm_datapath #(
    .PAGES(PAGES),
    .TLB_ENTRIES(TLB_ENTRIES),
    .FRAMES(FRAMES)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .cfg_valid(cfg_valid),
    .requester_id(requester_id),
    .operation(operation),
    .page_number(page_number),
    .frame_number(frame_number),
    .map_valid(map_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tlb_hit(tlb_hit),
    .table_hit(table_hit),
    .page_fault(page_fault),
    .frame_out(frame_out),
    .page_out(page_out)
  );

endmodule

// File: test/tb_tlb_page_table_mmu.sv
`timescale 1ns / 1ps
// Testbench for the TLB and page table MMU with an in-bench prediction of every translation.
module tb_tlb_page_table_mmu;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic       tlb_hit;
    logic       table_hit;
    logic       page_fault;
    logic [3:0] frame;
    logic [4:0] page;
  } mmu_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   operation;
  logic [tpm_pkg::PAGE_W-1:0]   page_number;
  logic [tpm_pkg::FRAME_W-1:0]  frame_number;
  logic                         map_valid;
  logic                         out_valid;
  logic                         out_ready;
  logic                         tlb_hit;
  logic                         table_hit;
  logic                         page_fault;
  logic [tpm_pkg::FRAME_W-1:0]  frame_out;
  logic [tpm_pkg::PAGE_W-1:0]   page_out;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [tpm_pkg::OWNER_W-1:0]  requester_id;

  tlb_page_table_mmu uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .page_number(page_number),
    .frame_number(frame_number),
    .map_valid(map_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tlb_hit(tlb_hit),
    .table_hit(table_hit),
    .page_fault(page_fault),
    .frame_out(frame_out),
    .page_out(page_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .requester_id(requester_id)
  );

  // Predicted state of the page table, the TLB and the replacement LFSR.
  logic                        page_valid [tpm_pkg::DEF_PAGES];
  logic [3:0]                  page_frame [tpm_pkg::DEF_PAGES];
  logic                        page_dirty [tpm_pkg::DEF_PAGES];
  logic [tpm_pkg::OWNER_W-1:0] page_owner [tpm_pkg::DEF_PAGES];
  logic [tpm_pkg::USE_W-1:0]   page_uses [tpm_pkg::DEF_PAGES];
  logic [4:0]                  slot_tag [tpm_pkg::DEF_TLB_ENTRIES];
  logic                        slot_present [tpm_pkg::DEF_TLB_ENTRIES];
  logic [3:0]                  slot_frame [tpm_pkg::DEF_TLB_ENTRIES];
  logic [tpm_pkg::LFSR_W-1:0]  victim_lfsr;
  logic [tpm_pkg::OWNER_W-1:0] owner_setting;

  mmu_result_t translation_q[$];

  int errors = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int seen_tlb_hits = 0;
  int seen_table_hits = 0;
  int seen_faults = 0;
  int seen_other = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic clear_prediction();
    for (int i = 0; i < tpm_pkg::DEF_PAGES; i++) begin
      page_valid[i] = 1'b0;
      page_frame[i] = '0;
      page_dirty[i] = 1'b0;
      page_owner[i] = '0;
      page_uses[i] = '0;
    end
    for (int i = 0; i < tpm_pkg::DEF_TLB_ENTRIES; i++) begin
      slot_tag[i] = '0;
      slot_present[i] = 1'b0;
      slot_frame[i] = '0;
    end
    victim_lfsr = tpm_pkg::LFSR_SEED;
    owner_setting = '0;
  endtask

  task automatic mmu_translate(input logic [1:0] op, input logic [4:0] pg, input logic [3:0] fr,
                               input logic mv, output mmu_result_t res);
    int idx;
    int slot;
    bit found;
    logic [3:0] f;
    res = '0;
    res.page = pg;
    idx = pg % tpm_pkg::DEF_PAGES;
    if (op == tpm_pkg::OP_READ || op == tpm_pkg::OP_WRITE) begin
      if (page_uses[idx] != tpm_pkg::USE_MAX) begin
        page_uses[idx]++;
      end
      found = 1'b0;
      slot = 0;
      for (int i = 0; i < tpm_pkg::DEF_TLB_ENTRIES; i++) begin
        if (!found && slot_present[i] && slot_tag[i] == idx) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (found) begin
        res.tlb_hit = 1'b1;
        res.frame = slot_frame[slot];
      end else if (page_valid[idx]) begin
        res.table_hit = 1'b1;
        res.frame = page_frame[idx];
        if (op == tpm_pkg::OP_WRITE) begin
          page_dirty[idx] = 1'b1;
        end
        victim_lfsr = (victim_lfsr >> 1) ^ (victim_lfsr[0] ? tpm_pkg::LFSR_TAPS : '0);
        slot = victim_lfsr % tpm_pkg::DEF_TLB_ENTRIES;
        slot_tag[slot] = 5'(idx);
        slot_frame[slot] = page_frame[idx];
        slot_present[slot] = 1'b1;
      end else begin
        res.page_fault = 1'b1;
        page_owner[idx] = owner_setting;
        if (op == tpm_pkg::OP_WRITE) begin
          page_dirty[idx] = 1'b1;
        end
      end
    end else if (op == tpm_pkg::OP_INSTALL) begin
      f = 4'(fr % tpm_pkg::DEF_FRAMES);
      page_valid[idx] = mv;
      page_frame[idx] = f;
      for (int i = 0; i < tpm_pkg::DEF_TLB_ENTRIES; i++) begin
        if (slot_present[i] && slot_tag[i] == idx) begin
          if (mv) begin
            slot_frame[i] = f;
          end else begin
            slot_present[i] = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic send_request(input logic [1:0] op, input logic [4:0] pg, input logic [3:0] fr,
                              input logic mv);
    mmu_result_t res;
    int gap;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    operation = op;
    page_number = pg;
    frame_number = fr;
    map_valid = mv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    mmu_translate(op, pg, fr, mv, res);
    translation_q.push_back(res);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_requester_id(input logic [tpm_pkg::OWNER_W-1:0] value);
    in_valid = 1'b0;
    while (translation_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    requester_id = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    owner_setting = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_unmapped_access();
    send_request(tpm_pkg::OP_READ, 5'd0, 4'd0, 1'b0);
    send_request(tpm_pkg::OP_WRITE, 5'd31, 4'd15, 1'b1);
    send_request(tpm_pkg::OP_READ, 5'd17, 4'd15, 1'b1);
  endtask

  task automatic test_unused_operation();
    send_request(OP_UNUSED, 5'd5, 4'd15, 1'b1);
    send_request(OP_UNUSED, 5'd31, 4'd0, 1'b0);
  endtask

  // A write that hits the TLB must still report only the hit and its frame.
  task automatic test_translation_path();
    send_request(tpm_pkg::OP_INSTALL, 5'd0, 4'd15, 1'b1);
    send_request(tpm_pkg::OP_READ, 5'd0, 4'd0, 1'b0);
    send_request(tpm_pkg::OP_WRITE, 5'd0, 4'd0, 1'b0);
    send_request(tpm_pkg::OP_INSTALL, 5'd31, 4'd0, 1'b1);
    send_request(tpm_pkg::OP_WRITE, 5'd31, 4'd15, 1'b1);
    send_request(tpm_pkg::OP_READ, 5'd31, 4'd15, 1'b0);
  endtask

  task automatic test_remap_and_unmap();
    send_request(tpm_pkg::OP_INSTALL, 5'd0, 4'd9, 1'b1);
    send_request(tpm_pkg::OP_READ, 5'd0, 4'd0, 1'b0);
    send_request(tpm_pkg::OP_INSTALL, 5'd0, 4'd0, 1'b0);
    send_request(tpm_pkg::OP_READ, 5'd0, 4'd0, 1'b0);
    send_request(tpm_pkg::OP_INSTALL, 5'd20, 4'd3, 1'b0);
  endtask

  task automatic test_tlb_replacement();
    for (int p = 1; p <= 3; p++) begin
      send_request(tpm_pkg::OP_INSTALL, p[4:0], 4'(p + 5), 1'b1);
      send_request(tpm_pkg::OP_READ, p[4:0], 4'd0, 1'b0);
      send_request(tpm_pkg::OP_WRITE, p[4:0], 4'd0, 1'b0);
    end
  endtask

  // Most accesses go to a small set of hot pages so that the TLB both hits and evicts.
  task automatic test_random_traffic(input int count, input int gap_level, input int stall_level);
    int r;
    logic [1:0] op;
    logic [4:0] pg;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        if (gap_level > 0 && $urandom_range(3) == 0) begin
          gap_pct = 0;
          stall_pct = 0;
        end else begin
          gap_pct = gap_level;
          stall_pct = stall_level;
        end
      end
      r = $urandom_range(99);
      op = (r < 45) ? tpm_pkg::OP_READ : (r < 75) ? tpm_pkg::OP_WRITE :
           (r < 95) ? tpm_pkg::OP_INSTALL : OP_UNUSED;
      pg = ($urandom_range(99) < 70) ? 5'($urandom_range(11)) : 5'($urandom_range(31));
      send_request(op, pg, 4'($urandom_range(15)), $urandom_range(99) < 75);
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    mmu_result_t exp;
    if (!rst && out_valid && out_ready) begin
      if (translation_q.size() == 0) begin
        $error("result transaction with no expectation: page_out %0d", page_out);
        errors++;
      end else begin
        exp = translation_q.pop_front();
        if (tlb_hit !== exp.tlb_hit) begin
          $error("tlb_hit mismatch: expected %0d, actual %0d", exp.tlb_hit, tlb_hit);
          errors++;
        end
        if (table_hit !== exp.table_hit) begin
          $error("table_hit mismatch: expected %0d, actual %0d", exp.table_hit, table_hit);
          errors++;
        end
        if (page_fault !== exp.page_fault) begin
          $error("page_fault mismatch: expected %0d, actual %0d", exp.page_fault, page_fault);
          errors++;
        end
        if (frame_out !== exp.frame) begin
          $error("frame_out mismatch: expected %0d, actual %0d", exp.frame, frame_out);
          errors++;
        end
        if (page_out !== exp.page) begin
          $error("page_out mismatch: expected %0d, actual %0d", exp.page, page_out);
          errors++;
        end
        if (exp.tlb_hit) begin
          seen_tlb_hits++;
        end else if (exp.table_hit) begin
          seen_table_hits++;
        end else if (exp.page_fault) begin
          seen_faults++;
        end else begin
          seen_other++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = tpm_pkg::OP_READ;
    page_number = '0;
    frame_number = '0;
    map_valid = 1'b0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    requester_id = '0;
    clear_prediction();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_unmapped_access();
    write_requester_id(16'hFFFF);
    test_unmapped_access();
    test_unused_operation();
    test_translation_path();
    test_remap_and_unmap();
    test_tlb_replacement();

    write_requester_id(16'h0000);
    test_random_traffic(400, 30, 30);
    write_requester_id(16'($urandom_range(16'hFFFF)));
    test_random_traffic(400, 15, 50);
    write_requester_id(16'h8000);
    test_random_traffic(300, 0, 0);

    in_valid = 1'b0;
    while (translation_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d transactions over %0d requester_id settings.", items_sent, cfg_writes);
    $display("Results: %0d TLB hits, %0d table hits, %0d page faults, %0d installs or unused.",
             seen_tlb_hits, seen_table_hits, seen_faults, seen_other);
    if (errors == 0 && translation_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
